// ===== design/fcr_pkg.sv =====
package fcr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] StartCharRst = 8'd64;  // '@'
  localparam logic [ByteW-1:0] EndCharRst   = 8'd38;  // '&'
  localparam logic [ByteW-1:0] LineEndRst   = 8'd10;  // newline

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OPEN_BYTE  = 2'd0,
    CFG_CLOSE_BYTE = 2'd1,
    CFG_LINE_END   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] open_byte;
    logic [ByteW-1:0] close_byte;
    logic [ByteW-1:0] line_end;
  } cfg_t;

  typedef struct packed {
    logic             write_en;
    logic [IdxW-1:0]  write_index;
    logic [ByteW-1:0] write_data;
    logic             command_done;
    logic [IdxW-1:0]  command_length;
    logic             frame_abort;
  } res_t;

endpackage

// ===== design/fcr_ifs.sv =====
interface fcr_rx_if
  import fcr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_value;

  modport source (output valid, output rx_value, input ready);
  modport sink (input valid, input rx_value, output ready);
endinterface

interface fcr_res_if
  import fcr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             write_en;
  logic [IdxW-1:0]  write_index;
  logic [ByteW-1:0] write_data;
  logic             command_done;
  logic [IdxW-1:0]  command_length;
  logic             frame_abort;

  modport source (
    output valid, output write_en, output write_index, output write_data,
    output command_done, output command_length, output frame_abort,
    input ready
  );
  modport sink (
    input valid, input write_en, input write_index, input write_data,
    input command_done, input command_length, input frame_abort,
    output ready
  );
endinterface

interface fcr_cfg_if
  import fcr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/fcr_cfg.sv =====
module fcr_cfg
  import fcr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  logic [CfgIdxW-1:0] wr_index_i,
  input  logic [ByteW-1:0]   wr_data_i,
  output logic               wr_ready_o,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        CFG_OPEN_BYTE:  cfg_d.open_byte  = wr_data_i;
        CFG_CLOSE_BYTE: cfg_d.close_byte = wr_data_i;
        CFG_LINE_END:   cfg_d.line_end   = wr_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_byte  <= StartCharRst;
      cfg_q.close_byte <= EndCharRst;
      cfg_q.line_end   <= LineEndRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/fcr_frame.sv =====
module fcr_frame
  import fcr_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  output logic             in_ready_o,
  input  logic             advance_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam int unsigned CntW = (BUFFER_SIZE > 2) ? $clog2(BUFFER_SIZE) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_SIZE - 1);

  logic             byte_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             in_frame_q, in_frame_d;
  logic             awaiting_q, awaiting_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             fire;
  logic             is_le;

  assign in_ready_o  = !byte_valid_q || advance_i;
  assign fire        = byte_valid_q && advance_i;
  assign res_valid_o = byte_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  // Priority follows the frame rules: start, stray byte, end, confirm, payload.
  always_comb begin
    is_le      = (byte_q == cfg_i.line_end);
    in_frame_d = in_frame_q;
    awaiting_d = awaiting_q;
    count_d    = count_q;
    res_o      = '0;
    if (byte_q == cfg_i.open_byte) begin
      in_frame_d = 1'b1;
      count_d    = '0;
    end else if (is_le != awaiting_q) begin
      in_frame_d        = 1'b0;
      awaiting_d        = 1'b0;
      count_d           = '0;
      res_o.frame_abort = 1'b1;
    end else if (byte_q == cfg_i.close_byte && in_frame_q) begin
      res_o.write_en    = 1'b1;
      res_o.write_index = IdxW'(count_q);
      in_frame_d        = 1'b0;
      awaiting_d        = 1'b1;
    end else if (is_le && awaiting_q) begin
      res_o.command_done = 1'b1;
      awaiting_d         = 1'b0;
    end else if (in_frame_q) begin
      if (count_q < CntMax) begin
        res_o.write_en    = 1'b1;
        res_o.write_index = IdxW'(count_q);
        res_o.write_data  = byte_q;
        count_d           = count_q + 1'b1;
      end else begin
        in_frame_d        = 1'b0;
        awaiting_d        = 1'b0;
        count_d           = '0;
        res_o.frame_abort = 1'b1;
      end
    end
    res_o.command_length = IdxW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      awaiting_q <= 1'b0;
      count_q    <= '0;
    end else if (fire) begin
      in_frame_q <= in_frame_d;
      awaiting_q <= awaiting_d;
      count_q    <= count_d;
    end
  end

  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.frame_abort |=> !in_frame_q && !awaiting_q && count_q == '0)
    else $error("frame state not cleared after abort");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("payload count beyond buffer limit");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_valid_q |-> $countones({res_o.write_en, res_o.command_done,
                                 res_o.frame_abort}) <= 1)
    else $error("write, done and abort in the same result");

  a_done_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.command_done |=> !awaiting_q && count_q == $past(count_q))
    else $error("confirmed command changed the latched length");

endmodule

// ===== design/framed_command_receiver.sv =====
// Path: an accepted request is held in the input register, then its result
// is held in the result register, from which it is offered.
// Throughput: one request per cycle; the frame flags and the payload counter
// update in a single pass, and a skid-free pipeline stalls only on the result.
// Reset: asynchronous, active low; clears the frame state, empties both stages
// and restores the delimiters to '@', '&' and newline.
module framed_command_receiver
  import fcr_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  fcr_rx_if.sink    rx_i,
  fcr_res_if.source res_o,
  fcr_cfg_if.sink   cfg_i
);

  cfg_t cfg;
  res_t res, res_q;
  logic res_valid;
  logic out_valid_q;
  logic advance;

  fcr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  fcr_frame #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (rx_i.valid),
    .in_byte_i   (rx_i.rx_value),
    .in_ready_o  (rx_i.ready),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign advance = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.write_en       = res_q.write_en;
  assign res_o.write_index    = res_q.write_index;
  assign res_o.write_data     = res_q.write_data;
  assign res_o.command_done   = res_q.command_done;
  assign res_o.command_length = res_q.command_length;
  assign res_o.frame_abort    = res_q.frame_abort;

endmodule
